/* sv/xte_pkg.sv */
// Package for the XML text escaper: escape kinds, queue entry type,
// character constants and the expansion tables. No dependencies.
package xte_pkg;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS,
    KIND_DASH,
    KIND_HEX
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_HEXLO = 8'h10;

  function automatic logic [7:0] hex_digit(logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else begin
      r = 8'h57 + {4'd0, d};
    end
    return r;
  endfunction

  function automatic logic [2:0] cmd_len(cmd_t c);
    logic [2:0] r;
    unique case (c.kind)
      KIND_PASS: r = 3'd1;
      KIND_LT:   r = 3'd4;
      KIND_GT:   r = 3'd4;
      KIND_AMP:  r = 3'd5;
      KIND_QUOT: r = 3'd6;
      KIND_APOS: r = 3'd6;
      KIND_DASH: r = 3'd5;
      KIND_HEX:  r = (c.data < CH_HEXLO) ? 3'd5 : 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [7:0] data, logic [2:0] idx);
    logic [7:0] r;
    logic       short_form;
    short_form = data < CH_HEXLO;
    unique case (idx)
      3'd0: r = CH_AMP;
      3'd1: r = CH_HASH;
      3'd2: r = 8'h78;
      3'd3: r = short_form ? hex_digit(data[3:0]) : hex_digit(data[7:4]);
      3'd4: r = short_form ? CH_SEMI : hex_digit(data[3:0]);
      default: r = CH_SEMI;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_char(kind_t k, logic [2:0] idx);
    logic [7:0] r;
    r = CH_SEMI;
    unique case (k)
      KIND_LT: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = 8'h6C;
          3'd2: r = 8'h74;
          default: r = CH_SEMI;
        endcase
      end
      KIND_GT: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = 8'h67;
          3'd2: r = 8'h74;
          default: r = CH_SEMI;
        endcase
      end
      KIND_AMP: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6D;
          3'd3: r = 8'h70;
          default: r = CH_SEMI;
        endcase
      end
      KIND_QUOT: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = 8'h71;
          3'd2: r = 8'h75;
          3'd3: r = 8'h6F;
          3'd4: r = 8'h74;
          default: r = CH_SEMI;
        endcase
      end
      KIND_APOS: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = 8'h61;
          3'd2: r = 8'h70;
          3'd3: r = 8'h6F;
          3'd4: r = 8'h73;
          default: r = CH_SEMI;
        endcase
      end
      KIND_DASH: begin
        unique case (idx)
          3'd0: r = CH_AMP;
          3'd1: r = CH_HASH;
          3'd2: r = 8'h34;
          3'd3: r = 8'h35;
          default: r = CH_SEMI;
        endcase
      end
      KIND_PASS: r = CH_SEMI;
      KIND_HEX:  r = CH_SEMI;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_char(cmd_t c, logic [2:0] idx);
    logic [7:0] r;
    unique case (c.kind)
      KIND_PASS: r = c.data;
      KIND_HEX:  r = hex_char(c.data, idx);
      default:   r = word_char(c.kind, idx);
    endcase
    return r;
  endfunction

endpackage

/* sv/xte_in_if.sv */
// Input channel of the XML text escaper: one raw text byte per beat.
// Depends on nothing.
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_string;

  modport source (output valid, output in_byte, output first_of_string, input ready);
  modport sink (input valid, input in_byte, input first_of_string, output ready);
endinterface

/* sv/xte_out_if.sv */
// Output channel of the XML text escaper: one escaped character per beat.
// Depends on nothing.
interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

/* sv/xte_front.sv */
// Front end: accepts input beats, tracks the dash memory and classifies
// each byte into an escape command. Depends on xte_pkg, xte_in_if.
module xte_front
  import xte_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  xte_in_if.sink ingress,
  output logic   cmd_valid,
  input  logic   cmd_ready,
  output cmd_t   cmd
);

  logic prev_was_dash;
  logic dash_before;
  logic is_dash;

  assign ingress.ready = cmd_ready;
  assign cmd_valid     = ingress.valid;
  assign dash_before   = prev_was_dash && !ingress.first_of_string;
  assign is_dash       = ingress.in_byte == CH_DASH;

  always_comb begin
    cmd.data = ingress.in_byte;
    priority if (ingress.in_byte == CH_LT) begin
      cmd.kind = KIND_LT;
    end else if (ingress.in_byte == CH_GT) begin
      cmd.kind = KIND_GT;
    end else if (ingress.in_byte == CH_AMP) begin
      cmd.kind = KIND_AMP;
    end else if (ingress.in_byte == CH_QUOT) begin
      cmd.kind = KIND_QUOT;
    end else if (ingress.in_byte == CH_APOS) begin
      cmd.kind = KIND_APOS;
    end else if (is_dash && dash_before) begin
      cmd.kind = KIND_DASH;
    end else if (ingress.in_byte < CH_SPACE || ingress.in_byte > CH_DEL) begin
      cmd.kind = KIND_HEX;
    end else begin
      cmd.kind = KIND_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_dash <= 1'b0;
    end else if (ingress.valid && ingress.ready) begin
      prev_was_dash <= is_dash;
    end
  end

endmodule

/* sv/xte_queue.sv */
// Command queue between front and back end, a small register FIFO.
// Depends on xte_pkg.
module xte_queue
  import xte_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = count != FULL_CNT;
  assign rd_valid = count != '0;
  assign rd_cmd   = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/xte_back.sv */
// Back end: expands the command at the queue head into escaped characters,
// one per beat, through a registered output. Depends on xte_pkg, xte_out_if.
module xte_back
  import xte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  xte_out_if.source egress
);

  logic [2:0] idx;
  logic       is_last;
  logic       load;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  assign is_last   = idx == (cmd_len(cmd) - 3'd1);
  assign load      = cmd_valid && (!out_valid || egress.ready);
  assign cmd_ready = load && is_last;

  assign egress.valid    = out_valid;
  assign egress.out_char = out_char;
  assign egress.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (egress.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= esc_char(cmd, idx);
      out_last <= is_last;
    end
  end

endmodule

/* sv/xml_text_escaper_top.sv */
// XML text escaper top level. Each accepted byte expands to 1 to 6 escaped
// characters, delivered one per cycle on egress while egress is ready; the
// egress path is one character wide, so the output carries one character at
// a time. Input bytes are classified on entry and queued (QDEPTH commands),
// so ingress keeps accepting while earlier bytes are still being expanded,
// until the queue is full. Depends on xte_pkg, xte_in_if,
// xte_out_if, xte_front, xte_queue, xte_back.
module xml_text_escaper_top
  import xte_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  xte_in_if.sink    ingress,
  xte_out_if.source egress
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  xte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ingress   (ingress),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  xte_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_cmd   (b_cmd)
  );

  xte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .egress    (egress)
  );

endmodule

/* sv/xte_checker.sv */
// Port-level checks for the XML text escaper, bound to the top level.
// Depends on xte_pkg, xml_text_escaper_top.
module xte_checker
  import xte_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  logic mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid <= !out_last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("egress beat changed while stalled");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside an escape sequence");

  a_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mid && !out_last |-> out_char == CH_AMP)
    else $error("escape sequence does not open with ampersand");

  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid && out_last |-> out_char == CH_SEMI)
    else $error("escape sequence does not close with semicolon");

endmodule

bind xml_text_escaper_top xte_checker u_xte_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (egress.valid),
  .out_ready (egress.ready),
  .out_char  (egress.out_char),
  .out_last  (egress.last)
);
